// ===== hw/rtl/srpg_pkg.sv =====
// Shared constants for the spiral rectangle point generator.
// No dependencies; used by spiral_rect_point_generator_core.
package srpg_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned CfgBits      = 13;
  localparam int unsigned OffsetBits   = 24;
  localparam int unsigned StatusBits   = 2;
  localparam int unsigned InDataBits   = 56;

  localparam logic [CfgBits-1:0] LatticeWidthRst  = 13'd64;
  localparam logic [CfgBits-1:0] LatticeHeightRst = 13'd64;

  // register indexes on the configuration port
  localparam logic RegLatticeWidth  = 1'b0;
  localparam logic RegLatticeHeight = 1'b1;

  // result status codes
  localparam logic [StatusBits-1:0] StPoint    = 2'd0;
  localparam logic [StatusBits-1:0] StFinished = 2'd1;
  localparam logic [StatusBits-1:0] StAccept   = 2'd2;
  localparam logic [StatusBits-1:0] StReject   = 2'd3;

  // input word function flag
  localparam logic FuncStart = 1'b0;

  // internal signed coordinate, wide enough for ring edges one step outside
  typedef logic signed [14:0] coord_t;

endpackage

// ===== hw/rtl/spiral_rect_point_generator_core.sv =====
// Spiral rectangle point generator: clips a rectangle to the lattice and
// emits its points from the center outward. Depends on srpg_pkg.
//
// Throughput 1 word per cycle while the skid stage is empty.
// The ring stepping, phase fall-through and one 14x13 offset multiply sit
// between the scan state registers and the result register; a skid stage
// keeps the input open while one result waits. Reset: scan done, lattice 64x64.
module spiral_rect_point_generator_core #(
  parameter int unsigned COORD_BITS = srpg_pkg::CoordBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic                               cfg_addr_i,
  input  logic [srpg_pkg::CfgBits-1:0]       cfg_wdata_i,
  // input words
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // origin_x[12:0], origin_y[25:13], span_x[38:26], span_y[51:39], zero pad
  input  logic [srpg_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // func
  input  logic                               s_axis_tuser_i,
  // result words
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // point_x, point_y, point_offset (24), zero pad
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [srpg_pkg::StatusBits-1:0]    m_axis_tuser_o
);

  localparam int unsigned OutDataBits = ((2*COORD_BITS+24+7)/8)*8;
  localparam int unsigned OffBits     = srpg_pkg::OffsetBits;

  typedef enum logic [2:0] {
    PH_RIGHT = 3'd0,
    PH_DOWN  = 3'd1,
    PH_LEFT  = 3'd2,
    PH_UP    = 3'd3,
    PH_NEXT  = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  // configuration
  logic [12:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= srpg_pkg::LatticeWidthRst;
      height_q <= srpg_pkg::LatticeHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == srpg_pkg::RegLatticeWidth) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // scan state
  phase_e                 phase_q, phase_d;
  srpg_pkg::coord_t       cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  srpg_pkg::coord_t       ring_l_q, ring_l_d, ring_r_q, ring_r_d;
  srpg_pkg::coord_t       ring_t_q, ring_t_d, ring_b_q, ring_b_d;
  logic [11:0]            clip_l_q, clip_l_d;
  logic [OffBits-1:0]     off_q, off_d;

  // handshake
  logic in_acc, out_pop;
  logic out_valid_q, skid_valid_q;
  logic [OutDataBits-1:0]          out_data_q, skid_data_q;
  logic [srpg_pkg::StatusBits-1:0] out_st_q, skid_st_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop = out_valid_q && m_axis_tready_i;

  // start decode
  logic signed [12:0] ox, oy;
  logic [12:0]        sx, sy;
  srpg_pkg::coord_t   oxe, oye, wd, ht, x0, y0, nx, ny, lim_x, lim_y;
  srpg_pkg::coord_t   low, odd, s_rl, s_rr, s_rt, s_rb, s_cx, s_cy;
  phase_e             s_ph;
  logic               reject;

  assign ox = s_axis_tdata_i[12:0];
  assign oy = s_axis_tdata_i[25:13];
  assign sx = s_axis_tdata_i[38:26];
  assign sy = s_axis_tdata_i[51:39];

  always_comb begin
    oxe   = {{2{ox[12]}}, ox};
    oye   = {{2{oy[12]}}, oy};
    wd    = {2'b00, width_q};
    ht    = {2'b00, height_q};
    x0    = ox[12] ? '0 : oxe;
    y0    = oy[12] ? '0 : oye;
    nx    = {2'b00, sx} + (ox[12] ? oxe : '0);
    ny    = {2'b00, sy} + (oy[12] ? oye : '0);
    lim_x = wd - x0;
    lim_y = ht - y0;
    if (lim_x < nx) begin
      nx = lim_x;
    end
    if (lim_y < ny) begin
      ny = lim_y;
    end
    reject = (width_q == '0) || (height_q == '0) || nx[14] || (nx == '0)
             || ny[14] || (ny == '0);
    if (ny < nx) begin
      odd  = {14'd0, ny[0]};
      low  = (ny - 15'sd1) >>> 1;
      s_rl = x0 + low;
      s_rr = x0 + nx - low - 15'sd1;
      s_rt = y0 + low;
      s_cy = s_rt;
      s_rb = s_rt - odd + 15'sd1;
      if (ny[0]) begin
        s_ph = PH_LEFT;
        s_cx = s_rr + 15'sd1;
      end else begin
        s_ph = PH_RIGHT;
        s_cx = s_rl - 15'sd1;
      end
    end else begin
      odd  = {14'd0, nx[0]};
      low  = (nx - 15'sd1) >>> 1;
      s_rl = x0 + low;
      s_rr = s_rl - odd + 15'sd1;
      s_rt = y0 + low;
      s_rb = y0 + ny - low - 15'sd1;
      if (nx[0]) begin
        s_ph = PH_UP;
        s_cx = s_rl;
        s_cy = s_rb + 15'sd1;
      end else begin
        s_ph = PH_RIGHT;
        s_cx = s_rl - 15'sd1;
        s_cy = s_rt;
      end
    end
  end

  // next-point decode: first phase from the current one that can move
  logic [4:0]       can_go;
  phase_e           act;
  logic             act_found;
  logic             edge_out;
  srpg_pkg::coord_t nl, nt;

  assign nl       = ring_l_q - 15'sd1;
  assign nt       = ring_t_q - 15'sd1;
  assign edge_out = nl < $signed({3'b000, clip_l_q});

  always_comb begin
    can_go[PH_RIGHT] = cur_x_q != ring_r_q;
    can_go[PH_DOWN]  = cur_y_q != ring_b_q;
    can_go[PH_LEFT]  = cur_x_q != ring_l_q;
    can_go[PH_UP]    = cur_y_q > ring_t_q + 15'sd1;
    can_go[PH_NEXT]  = 1'b1;
    act       = PH_DONE;
    act_found = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (!act_found && (3'(k) >= phase_q) && can_go[k]) begin
        act       = phase_e'(3'(k));
        act_found = 1'b1;
      end
    end
  end

  // shared offset multiply
  srpg_pkg::coord_t mul_y, mul_x;
  logic [26:0]      prod;
  logic [OffBits-1:0] mul_off;

  assign mul_y   = (s_axis_tuser_i == srpg_pkg::FuncStart) ? s_cy : nt;
  assign mul_x   = (s_axis_tuser_i == srpg_pkg::FuncStart) ? s_cx : nl;
  assign prod    = mul_y[13:0] * width_q;
  assign mul_off = prod[OffBits-1:0] + {{(OffBits-15){mul_x[14]}}, mul_x};

  // step and result
  logic [srpg_pkg::StatusBits-1:0] res_st;
  logic [OutDataBits-1:0]          res_data;
  logic [31:0]                     px, py;

  always_comb begin
    phase_d  = phase_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    ring_l_d = ring_l_q;
    ring_r_d = ring_r_q;
    ring_t_d = ring_t_q;
    ring_b_d = ring_b_q;
    clip_l_d = clip_l_q;
    off_d    = off_q;
    res_st   = srpg_pkg::StFinished;
    if (s_axis_tuser_i == srpg_pkg::FuncStart) begin
      if (reject) begin
        phase_d = PH_DONE;
        res_st  = srpg_pkg::StReject;
      end else begin
        phase_d  = s_ph;
        cur_x_d  = s_cx;
        cur_y_d  = s_cy;
        ring_l_d = s_rl;
        ring_r_d = s_rr;
        ring_t_d = s_rt;
        ring_b_d = s_rb;
        clip_l_d = x0[11:0];
        off_d    = mul_off;
        res_st   = srpg_pkg::StAccept;
      end
    end else begin
      case (act)
        PH_RIGHT: begin
          phase_d = PH_RIGHT;
          cur_x_d = cur_x_q + 15'sd1;
          off_d   = off_q + 24'd1;
          res_st  = srpg_pkg::StPoint;
        end
        PH_DOWN: begin
          phase_d = PH_DOWN;
          cur_y_d = cur_y_q + 15'sd1;
          off_d   = off_q + {11'd0, width_q};
          res_st  = srpg_pkg::StPoint;
        end
        PH_LEFT: begin
          phase_d = PH_LEFT;
          cur_x_d = cur_x_q - 15'sd1;
          off_d   = off_q - 24'd1;
          res_st  = srpg_pkg::StPoint;
        end
        PH_UP: begin
          phase_d = PH_UP;
          cur_y_d = cur_y_q - 15'sd1;
          off_d   = off_q - {11'd0, width_q};
          res_st  = srpg_pkg::StPoint;
        end
        PH_NEXT: begin
          if (edge_out) begin
            phase_d = PH_DONE;
          end else begin
            phase_d  = PH_RIGHT;
            ring_l_d = nl;
            ring_t_d = nt;
            ring_r_d = ring_r_q + 15'sd1;
            ring_b_d = ring_b_q + 15'sd1;
            cur_x_d  = nl;
            cur_y_d  = nt;
            off_d    = mul_off;
            res_st   = srpg_pkg::StPoint;
          end
        end
        default: begin
          res_st = srpg_pkg::StFinished;
        end
      endcase
    end
    // emitted points lie inside the lattice, so coordinates are non-negative
    px       = {17'd0, cur_x_d};
    py       = {17'd0, cur_y_d};
    res_data = '0;
    if (res_st == srpg_pkg::StPoint) begin
      res_data[COORD_BITS-1:0]                   = px[COORD_BITS-1:0];
      res_data[2*COORD_BITS-1:COORD_BITS]        = py[COORD_BITS-1:0];
      res_data[2*COORD_BITS+OffBits-1:2*COORD_BITS] = off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DONE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      ring_l_q <= '0;
      ring_r_q <= '0;
      ring_t_q <= '0;
      ring_b_q <= '0;
      clip_l_q <= '0;
      off_q    <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      ring_l_q <= ring_l_d;
      ring_r_q <= ring_r_d;
      ring_t_q <= ring_t_d;
      ring_b_q <= ring_b_d;
      clip_l_q <= clip_l_d;
      off_q    <= off_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_data_q <= skid_data_q;
        out_st_q   <= skid_st_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_pop) begin
        skid_data_q <= res_data;
        skid_st_q   <= res_st;
      end else begin
        out_data_q <= res_data;
        out_st_q   <= res_st;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_st_q;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without a result word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i))
    else $error("skid filled while result could drain");

  a_reject_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (res_st == srpg_pkg::StReject)) |=> (phase_q == PH_DONE))
    else $error("rejected start left scan active");

endmodule
